>>> rtl/core/d2q9_bgk_collision_top_macros.svh
// assertion macros for the d2q9 bgk collision block
`ifndef D2Q9_BGK_COLLISION_TOP_MACROS_SVH
`define D2Q9_BGK_COLLISION_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define D2Q_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define D2Q_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, also checked through reset
`define D2Q_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/d2q_pkg.sv
// shared constants and types for the d2q9 bgk collision block
`default_nettype none
package d2q_pkg;

   localparam int NUM_DIR = 9;

   typedef enum logic [3:0] {
      DIR_REST,
      DIR_NORTH,
      DIR_EAST,
      DIR_SOUTH,
      DIR_WEST,
      DIR_NORTHEAST,
      DIR_NORTHWEST,
      DIR_SOUTHEAST,
      DIR_SOUTHWEST
   } dir_type;

endpackage
`default_nettype wire

>>> rtl/core/d2q_interfaces.sv
// valid/ready channel interfaces for cell transactions and result transactions
`default_nettype none
interface d2q_req_if #(parameter int VALUE_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] rest_in;
   logic signed [VALUE_WIDTH-1:0] north_in;
   logic signed [VALUE_WIDTH-1:0] east_in;
   logic signed [VALUE_WIDTH-1:0] south_in;
   logic signed [VALUE_WIDTH-1:0] west_in;
   logic signed [VALUE_WIDTH-1:0] northeast_in;
   logic signed [VALUE_WIDTH-1:0] northwest_in;
   logic signed [VALUE_WIDTH-1:0] southeast_in;
   logic signed [VALUE_WIDTH-1:0] southwest_in;

   modport source (
      output valid, rest_in, north_in, east_in, south_in, west_in,
             northeast_in, northwest_in, southeast_in, southwest_in,
      input  ready
   );
   modport sink (
      input  valid, rest_in, north_in, east_in, south_in, west_in,
             northeast_in, northwest_in, southeast_in, southwest_in,
      output ready
   );
endinterface

interface d2q_rsp_if #(parameter int VALUE_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] rest_out;
   logic signed [VALUE_WIDTH-1:0] north_out;
   logic signed [VALUE_WIDTH-1:0] east_out;
   logic signed [VALUE_WIDTH-1:0] south_out;
   logic signed [VALUE_WIDTH-1:0] west_out;
   logic signed [VALUE_WIDTH-1:0] northeast_out;
   logic signed [VALUE_WIDTH-1:0] northwest_out;
   logic signed [VALUE_WIDTH-1:0] southeast_out;
   logic signed [VALUE_WIDTH-1:0] southwest_out;
   logic signed [VALUE_WIDTH-1:0] density_out;
   logic signed [VALUE_WIDTH-1:0] velocity_x_out;
   logic signed [VALUE_WIDTH-1:0] velocity_y_out;

   modport source (
      output valid, rest_out, north_out, east_out, south_out, west_out,
             northeast_out, northwest_out, southeast_out, southwest_out,
             density_out, velocity_x_out, velocity_y_out,
      input  ready
   );
   modport sink (
      input  valid, rest_out, north_out, east_out, south_out, west_out,
             northeast_out, northwest_out, southeast_out, southwest_out,
             density_out, velocity_x_out, velocity_y_out,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/core/d2q9_bgk_collision_top.sv
// throughput: one cell per cycle while results are taken, set by the single-bit divider
// stages and the registered relaxation multiplies, all stages advancing together
// stall: the whole pipeline holds while a result waits, nothing lost or repeated
// reset: synchronous, clears all stage valid bits and loads omega = 1.0
`default_nettype none
module d2q9_bgk_collision_top #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 28
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [FRAC_BITS+1:0] csr_wr_data,
   d2q_req_if.sink              req_ch,
   d2q_rsp_if.source            rsp_ch
);
   import d2q_pkg::*;

   localparam int W = VALUE_WIDTH;

   logic [FRAC_BITS+1:0]         relax_rate_in, relax_rate_ff;
   logic                         advance;
   logic [NUM_DIR-1:0][W-1:0]    in_dist;
   logic                         mid_valid;
   logic [NUM_DIR-1:0][W-1:0]    mid_dist;
   logic [W-1:0]                 mid_rho, mid_ux, mid_uy;
   logic                         out_valid;
   logic [NUM_DIR-1:0][W-1:0]    out_dist;
   logic [W-1:0]                 out_rho, out_ux, out_uy;

   assign relax_rate_in = csr_wr_en ? csr_wr_data : relax_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_rate_ff <= (FRAC_BITS+2)'(1) << FRAC_BITS;
      end else begin
         relax_rate_ff <= relax_rate_in;
      end
   end

   assign advance      = !out_valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   assign in_dist[DIR_REST]      = req_ch.rest_in;
   assign in_dist[DIR_NORTH]     = req_ch.north_in;
   assign in_dist[DIR_EAST]      = req_ch.east_in;
   assign in_dist[DIR_SOUTH]     = req_ch.south_in;
   assign in_dist[DIR_WEST]      = req_ch.west_in;
   assign in_dist[DIR_NORTHEAST] = req_ch.northeast_in;
   assign in_dist[DIR_NORTHWEST] = req_ch.northwest_in;
   assign in_dist[DIR_SOUTHEAST] = req_ch.southeast_in;
   assign in_dist[DIR_SOUTHWEST] = req_ch.southwest_in;

   d2q_front #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_ch.valid),
      .in_dist   (in_dist),
      .out_valid (mid_valid),
      .out_dist  (mid_dist),
      .out_rho   (mid_rho),
      .out_ux    (mid_ux),
      .out_uy    (mid_uy)
   );

   d2q_relax #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_relax (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .omega     (relax_rate_ff),
      .in_valid  (mid_valid),
      .in_dist   (mid_dist),
      .in_rho    (mid_rho),
      .in_ux     (mid_ux),
      .in_uy     (mid_uy),
      .out_valid (out_valid),
      .out_dist  (out_dist),
      .out_rho   (out_rho),
      .out_ux    (out_ux),
      .out_uy    (out_uy)
   );

   assign rsp_ch.valid          = out_valid;
   assign rsp_ch.rest_out       = out_dist[DIR_REST];
   assign rsp_ch.north_out      = out_dist[DIR_NORTH];
   assign rsp_ch.east_out       = out_dist[DIR_EAST];
   assign rsp_ch.south_out      = out_dist[DIR_SOUTH];
   assign rsp_ch.west_out       = out_dist[DIR_WEST];
   assign rsp_ch.northeast_out  = out_dist[DIR_NORTHEAST];
   assign rsp_ch.northwest_out  = out_dist[DIR_NORTHWEST];
   assign rsp_ch.southeast_out  = out_dist[DIR_SOUTHEAST];
   assign rsp_ch.southwest_out  = out_dist[DIR_SOUTHWEST];
   assign rsp_ch.density_out    = out_rho;
   assign rsp_ch.velocity_x_out = out_ux;
   assign rsp_ch.velocity_y_out = out_uy;

endmodule
`default_nettype wire

>>> rtl/core/d2q_front.sv
// density and momentum sums followed by a pipelined bit-per-stage velocity divider
`default_nettype none
module d2q_front #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 28
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              advance,
   input  logic                                              in_valid,
   input  logic [d2q_pkg::NUM_DIR-1:0][VALUE_WIDTH-1:0]      in_dist,
   output logic                                              out_valid,
   output logic [d2q_pkg::NUM_DIR-1:0][VALUE_WIDTH-1:0]      out_dist,
   output logic [VALUE_WIDTH-1:0]                            out_rho,
   output logic [VALUE_WIDTH-1:0]                            out_ux,
   output logic [VALUE_WIDTH-1:0]                            out_uy
);
   import d2q_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int SW = W + 4;
   localparam int NL = 2;

   localparam logic [W-1:0]         VMAX    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]         VMIN    = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [SW-1:0] SUM_MAX = {{5{1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = {{5{1'b1}}, {(W-1){1'b0}}};

   typedef logic [NUM_DIR-1:0][W-1:0] dist_type;

   function automatic logic signed [SW-1:0] sx(input logic [W-1:0] v);
      return {{4{v[W-1]}}, v};
   endfunction

   function automatic logic [W-1:0] clampw(input logic signed [SW-1:0] x);
      if (x > SUM_MAX) return VMAX;
      if (x < SUM_MIN) return VMIN;
      return x[W-1:0];
   endfunction

   function automatic logic [W-1:0] mag(input logic [W-1:0] a);
      return a[W-1] ? (W'(0) - a) : a;
   endfunction

   // sum stage
   logic                s1_vld_in, s1_vld_ff;
   dist_type            s1_dist_in, s1_dist_ff;
   logic [W-1:0]        s1_rho_in, s1_rho_ff;
   logic [W-1:0]        s1_mom_in [NL];
   logic [W-1:0]        s1_mom_ff [NL];
   logic signed [SW-1:0] rho_sum, mx_sum, my_sum;

   always_comb begin
      rho_sum = sx(in_dist[DIR_REST]) + sx(in_dist[DIR_NORTH]) + sx(in_dist[DIR_EAST])
              + sx(in_dist[DIR_SOUTH]) + sx(in_dist[DIR_WEST])
              + sx(in_dist[DIR_NORTHEAST]) + sx(in_dist[DIR_NORTHWEST])
              + sx(in_dist[DIR_SOUTHEAST]) + sx(in_dist[DIR_SOUTHWEST]);
      mx_sum  = sx(in_dist[DIR_EAST]) + sx(in_dist[DIR_NORTHEAST])
              + sx(in_dist[DIR_SOUTHEAST]) - sx(in_dist[DIR_WEST])
              - sx(in_dist[DIR_NORTHWEST]) - sx(in_dist[DIR_SOUTHWEST]);
      my_sum  = sx(in_dist[DIR_NORTH]) + sx(in_dist[DIR_NORTHEAST])
              + sx(in_dist[DIR_NORTHWEST]) - sx(in_dist[DIR_SOUTH])
              - sx(in_dist[DIR_SOUTHEAST]) - sx(in_dist[DIR_SOUTHWEST]);
      s1_vld_in    = in_valid;
      s1_dist_in   = in_dist;
      s1_rho_in    = clampw(rho_sum);
      s1_mom_in[0] = clampw(mx_sum);
      s1_mom_in[1] = clampw(my_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= s1_vld_in;
      end
      if (advance) begin
         s1_dist_ff <= s1_dist_in;
         s1_rho_ff  <= s1_rho_in;
         s1_mom_ff  <= s1_mom_in;
      end
   end

   // divider stages, index 0 is the set-up stage
   logic         dv_vld_in  [0:W];
   logic         dv_vld_ff  [0:W];
   dist_type     dv_dist_in [0:W];
   dist_type     dv_dist_ff [0:W];
   logic [W-1:0] dv_rho_in  [0:W];
   logic [W-1:0] dv_rho_ff  [0:W];
   logic         dv_pos_in  [0:W];
   logic         dv_pos_ff  [0:W];
   logic [W-1:0] dv_mag_in  [0:W][NL];
   logic [W-1:0] dv_mag_ff  [0:W][NL];
   logic [W-1:0] dv_rem_in  [0:W][NL];
   logic [W-1:0] dv_rem_ff  [0:W][NL];
   logic [W-1:0] dv_q_in    [0:W][NL];
   logic [W-1:0] dv_q_ff    [0:W][NL];
   logic         dv_neg_in  [0:W][NL];
   logic         dv_neg_ff  [0:W][NL];
   logic         dv_over_in [0:W][NL];
   logic         dv_over_ff [0:W][NL];

   always_comb begin
      dv_vld_in[0]  = s1_vld_ff;
      dv_dist_in[0] = s1_dist_ff;
      dv_rho_in[0]  = s1_rho_ff;
      dv_pos_in[0]  = !s1_rho_ff[W-1] && (s1_rho_ff != '0);
      for (int l = 0; l < NL; l++) begin
         dv_mag_in[0][l]  = mag(s1_mom_ff[l]);
         dv_neg_in[0][l]  = s1_mom_ff[l][W-1];
         dv_rem_in[0][l]  = mag(s1_mom_ff[l]) >> (W - F);
         dv_over_in[0][l] = (mag(s1_mom_ff[l]) >> (W - F)) >= s1_rho_ff;
         dv_q_in[0][l]    = '0;
      end
   end

   for (genvar k = 0; k < W; k++) begin : g_div
      localparam int BIT = W - 1 - k;
      logic [W-1:0] shifted [NL];
      logic         ge      [NL];
      logic         nbit    [NL];

      for (genvar l = 0; l < NL; l++) begin : g_lane
         if (BIT >= F) begin : g_num
            assign nbit[l] = dv_mag_ff[k][l][BIT-F];
         end else begin : g_zero
            assign nbit[l] = 1'b0;
         end
      end

      always_comb begin
         dv_vld_in[k+1]  = dv_vld_ff[k];
         dv_dist_in[k+1] = dv_dist_ff[k];
         dv_rho_in[k+1]  = dv_rho_ff[k];
         dv_pos_in[k+1]  = dv_pos_ff[k];
         for (int l = 0; l < NL; l++) begin
            shifted[l]         = {dv_rem_ff[k][l][W-2:0], nbit[l]};
            ge[l]              = shifted[l] >= dv_rho_ff[k];
            dv_rem_in[k+1][l]  = ge[l] ? (shifted[l] - dv_rho_ff[k]) : shifted[l];
            dv_q_in[k+1][l]    = dv_q_ff[k][l] | (W'(ge[l]) << BIT);
            dv_mag_in[k+1][l]  = dv_mag_ff[k][l];
            dv_neg_in[k+1][l]  = dv_neg_ff[k][l];
            dv_over_in[k+1][l] = dv_over_ff[k][l];
         end
      end
   end

   for (genvar s = 0; s <= W; s++) begin : g_dv_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[s] <= 1'b0;
         end else if (advance) begin
            dv_vld_ff[s] <= dv_vld_in[s];
         end
         if (advance) begin
            dv_dist_ff[s] <= dv_dist_in[s];
            dv_rho_ff[s]  <= dv_rho_in[s];
            dv_pos_ff[s]  <= dv_pos_in[s];
            dv_mag_ff[s]  <= dv_mag_in[s];
            dv_rem_ff[s]  <= dv_rem_in[s];
            dv_q_ff[s]    <= dv_q_in[s];
            dv_neg_ff[s]  <= dv_neg_in[s];
            dv_over_ff[s] <= dv_over_in[s];
         end
      end
   end

   // sign and saturate the quotients, or zero them when the density is not positive
   logic         fn_vld_in, fn_vld_ff;
   dist_type     fn_dist_in, fn_dist_ff;
   logic [W-1:0] fn_rho_in, fn_rho_ff;
   logic [W-1:0] fn_u_in [NL];
   logic [W-1:0] fn_u_ff [NL];
   logic [W-1:0] lim     [NL];
   logic [W-1:0] qsat    [NL];

   always_comb begin
      fn_vld_in  = dv_vld_ff[W];
      fn_dist_in = dv_dist_ff[W];
      fn_rho_in  = dv_rho_ff[W];
      for (int l = 0; l < NL; l++) begin
         lim[l]  = dv_neg_ff[W][l] ? VMIN : VMAX;
         qsat[l] = (dv_over_ff[W][l] || (dv_q_ff[W][l] > lim[l])) ? lim[l] : dv_q_ff[W][l];
         if (!dv_pos_ff[W]) begin
            fn_u_in[l] = '0;
         end else begin
            fn_u_in[l] = dv_neg_ff[W][l] ? (W'(0) - qsat[l]) : qsat[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fn_vld_ff <= 1'b0;
      end else if (advance) begin
         fn_vld_ff <= fn_vld_in;
      end
      if (advance) begin
         fn_dist_ff <= fn_dist_in;
         fn_rho_ff  <= fn_rho_in;
         fn_u_ff    <= fn_u_in;
      end
   end

   assign out_valid = fn_vld_ff;
   assign out_dist  = fn_dist_ff;
   assign out_rho   = fn_rho_ff;
   assign out_ux    = fn_u_ff[0];
   assign out_uy    = fn_u_ff[1];

endmodule
`default_nettype wire

>>> rtl/core/d2q_relax.sv
// equilibrium and bgk relaxation pipeline, each product rounded in the stage after its multiply
`default_nettype none
module d2q_relax #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 28
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         advance,
   input  logic [FRAC_BITS+1:0]                         omega,
   input  logic                                         in_valid,
   input  logic [d2q_pkg::NUM_DIR-1:0][VALUE_WIDTH-1:0] in_dist,
   input  logic [VALUE_WIDTH-1:0]                       in_rho,
   input  logic [VALUE_WIDTH-1:0]                       in_ux,
   input  logic [VALUE_WIDTH-1:0]                       in_uy,
   output logic                                         out_valid,
   output logic [d2q_pkg::NUM_DIR-1:0][VALUE_WIDTH-1:0] out_dist,
   output logic [VALUE_WIDTH-1:0]                       out_rho,
   output logic [VALUE_WIDTH-1:0]                       out_ux,
   output logic [VALUE_WIDTH-1:0]                       out_uy
);
   import d2q_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W;
   localparam int NS = 13;

   localparam logic [W-1:0]  VMAX     = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  VMIN     = {1'b1, {(W-1){1'b0}}};
   localparam logic [PW:0]   HALF     = (PW+1)'(1) << (F - 1);
   localparam logic [PW:0]   LIM_POS  = (PW+1)'(VMAX);
   localparam logic [PW:0]   LIM_NEG  = LIM_POS + (PW+1)'(1);
   localparam logic [W-1:0]  ONE      = W'(64'd1 << F);
   localparam logic [W-1:0]  C19      = W'(((64'd1 << F) + 64'd4) / 64'd9);
   localparam logic [W-1:0]  C49      = W'(((64'd4 << F) + 64'd4) / 64'd9);
   localparam logic [W-1:0]  C136     = W'(((64'd1 << F) + 64'd18) / 64'd36);
   localparam logic [W-1:0]  C15      = W'(64'd3 << (F - 1));
   localparam logic [W-1:0]  C45      = W'(64'd9 << (F - 1));

   // first product group
   localparam int P_XX  = 0;
   localparam int P_YY  = 1;
   localparam int P_XY  = 2;
   localparam int P_R9  = 3;
   localparam int P_R49 = 4;
   localparam int P_R36 = 5;
   // second product group
   localparam int Q_F15 = 0;
   localparam int Q_AX  = 1;
   localparam int Q_AY  = 2;
   // weights
   localparam int WT_9  = 0;
   localparam int WT_49 = 1;
   localparam int WT_36 = 2;

   typedef logic [NUM_DIR-1:0][W-1:0] dist_type;

   function automatic logic [W-1:0] qadd(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] qsub(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] mag(input logic [W-1:0] a);
      return a[W-1] ? (W'(0) - a) : a;
   endfunction

   function automatic logic [PW-1:0] mulmag(input logic [W-1:0] a, input logic [W-1:0] b);
      return PW'(mag(a)) * PW'(mag(b));
   endfunction

   function automatic logic [W-1:0] rnd(input logic [PW-1:0] p, input logic neg);
      logic [PW:0] full;
      logic [PW:0] m;
      full = {1'b0, p} + HALF;
      m    = full >> F;
      if (neg && (m > LIM_NEG)) m = LIM_NEG;
      if (!neg && (m > LIM_POS)) m = LIM_POS;
      return neg ? (W'(0) - m[W-1:0]) : m[W-1:0];
   endfunction

   // carried cell data
   logic         vld_in  [1:NS];
   logic         vld_ff  [1:NS];
   dist_type     dist_in [1:NS];
   dist_type     dist_ff [1:NS];
   logic [W-1:0] rho_in  [1:NS];
   logic [W-1:0] rho_ff  [1:NS];
   logic [W-1:0] ux_in   [1:NS];
   logic [W-1:0] ux_ff   [1:NS];
   logic [W-1:0] uy_in   [1:NS];
   logic [W-1:0] uy_ff   [1:NS];

   always_comb begin
      vld_in[1]  = in_valid;
      dist_in[1] = in_dist;
      rho_in[1]  = in_rho;
      ux_in[1]   = in_ux;
      uy_in[1]   = in_uy;
      for (int k = 2; k <= NS; k++) begin
         vld_in[k]  = vld_ff[k-1];
         dist_in[k] = dist_ff[k-1];
         rho_in[k]  = rho_ff[k-1];
         ux_in[k]   = ux_ff[k-1];
         uy_in[k]   = uy_ff[k-1];
      end
   end

   // stage registers
   logic [W-1:0]  s1_u3_in [2],  s1_u3_ff [2];
   logic [PW-1:0] s1_pm_in [6],  s1_pm_ff [6];
   logic          s1_ps_in [6],  s1_ps_ff [6];
   logic [W-1:0]  s2_v_in [6],   s2_v_ff [6];
   logic [W-1:0]  s2_u3_in [2],  s2_u3_ff [2];
   logic [W-1:0]  s3_uxx_in, s3_uxx_ff, s3_uyy_in, s3_uyy_ff;
   logic [W-1:0]  s3_u2_in, s3_u2_ff, s3_uxy2_in, s3_uxy2_ff;
   logic [W-1:0]  s3_wt_in [3],  s3_wt_ff [3];
   logic [W-1:0]  s3_u3_in [2],  s3_u3_ff [2];
   logic [W-1:0]  s4_sp_in, s4_sp_ff, s4_sm_in, s4_sm_ff;
   logic [PW-1:0] s4_pm_in [3],  s4_pm_ff [3];
   logic          s4_ps_in [3],  s4_ps_ff [3];
   logic [W-1:0]  s4_wt_in [3],  s4_wt_ff [3];
   logic [W-1:0]  s4_u3_in [2],  s4_u3_ff [2];
   logic [W-1:0]  s5_v_in [3],   s5_v_ff [3];
   logic [PW-1:0] s5_pm_in [2],  s5_pm_ff [2];
   logic          s5_ps_in [2],  s5_ps_ff [2];
   logic [W-1:0]  s5_wt_in [3],  s5_wt_ff [3];
   logic [W-1:0]  s5_u3_in [2],  s5_u3_ff [2];
   logic [W-1:0]  s6_d_in [2],   s6_d_ff [2];
   logic [W-1:0]  s6_part_in [NUM_DIR], s6_part_ff [NUM_DIR];
   logic [W-1:0]  s6_f15_in, s6_f15_ff;
   logic [W-1:0]  s6_wt_in [3],  s6_wt_ff [3];
   logic [W-1:0]  s7_poly_in [NUM_DIR], s7_poly_ff [NUM_DIR];
   logic [W-1:0]  s7_wt_in [3],  s7_wt_ff [3];
   logic [PW-1:0] s8_pm_in [NUM_DIR],  s8_pm_ff [NUM_DIR];
   logic          s8_ps_in [NUM_DIR],  s8_ps_ff [NUM_DIR];
   logic [W-1:0]  s9_feq_in [NUM_DIR], s9_feq_ff [NUM_DIR];
   logic [W-1:0]  s10_diff_in [NUM_DIR], s10_diff_ff [NUM_DIR];
   logic [PW-1:0] s11_pm_in [NUM_DIR], s11_pm_ff [NUM_DIR];
   logic          s11_ps_in [NUM_DIR], s11_ps_ff [NUM_DIR];
   logic [W-1:0]  s12_v_in [NUM_DIR],  s12_v_ff [NUM_DIR];
   logic [W-1:0]  s13_out_in [NUM_DIR], s13_out_ff [NUM_DIR];

   logic [W-1:0]  omega_w;
   logic [W-1:0]  wsel;

   assign omega_w = W'(omega);

   always_comb begin
      // velocity products and density weights
      s1_u3_in[0] = qadd(qadd(in_ux, in_ux), in_ux);
      s1_u3_in[1] = qadd(qadd(in_uy, in_uy), in_uy);
      s1_pm_in[P_XX]  = mulmag(in_ux, in_ux);
      s1_ps_in[P_XX]  = 1'b0;
      s1_pm_in[P_YY]  = mulmag(in_uy, in_uy);
      s1_ps_in[P_YY]  = 1'b0;
      s1_pm_in[P_XY]  = mulmag(in_ux, in_uy);
      s1_ps_in[P_XY]  = in_ux[W-1] ^ in_uy[W-1];
      s1_pm_in[P_R9]  = mulmag(C19, in_rho);
      s1_ps_in[P_R9]  = in_rho[W-1];
      s1_pm_in[P_R49] = mulmag(C49, in_rho);
      s1_ps_in[P_R49] = in_rho[W-1];
      s1_pm_in[P_R36] = mulmag(C136, in_rho);
      s1_ps_in[P_R36] = in_rho[W-1];

      for (int j = 0; j < 6; j++) begin
         s2_v_in[j] = rnd(s1_pm_ff[j], s1_ps_ff[j]);
      end
      s2_u3_in = s1_u3_ff;

      s3_uxx_in    = s2_v_ff[P_XX];
      s3_uyy_in    = s2_v_ff[P_YY];
      s3_u2_in     = qadd(s2_v_ff[P_XX], s2_v_ff[P_YY]);
      s3_uxy2_in   = qadd(s2_v_ff[P_XY], s2_v_ff[P_XY]);
      s3_wt_in[WT_9]  = s2_v_ff[P_R9];
      s3_wt_in[WT_49] = s2_v_ff[P_R49];
      s3_wt_in[WT_36] = s2_v_ff[P_R36];
      s3_u3_in = s2_u3_ff;

      s4_sp_in = qadd(s3_u2_ff, s3_uxy2_ff);
      s4_sm_in = qsub(s3_u2_ff, s3_uxy2_ff);
      s4_pm_in[Q_F15] = mulmag(C15, s3_u2_ff);
      s4_ps_in[Q_F15] = s3_u2_ff[W-1];
      s4_pm_in[Q_AX]  = mulmag(C45, s3_uxx_ff);
      s4_ps_in[Q_AX]  = s3_uxx_ff[W-1];
      s4_pm_in[Q_AY]  = mulmag(C45, s3_uyy_ff);
      s4_ps_in[Q_AY]  = s3_uyy_ff[W-1];
      s4_wt_in = s3_wt_ff;
      s4_u3_in = s3_u3_ff;

      for (int j = 0; j < 3; j++) begin
         s5_v_in[j] = rnd(s4_pm_ff[j], s4_ps_ff[j]);
      end
      s5_pm_in[0] = mulmag(C45, s4_sp_ff);
      s5_ps_in[0] = s4_sp_ff[W-1];
      s5_pm_in[1] = mulmag(C45, s4_sm_ff);
      s5_ps_in[1] = s4_sm_ff[W-1];
      s5_wt_in = s4_wt_ff;
      s5_u3_in = s4_u3_ff;

      // dp, dm and the leading terms of each polynomial
      s6_d_in[0] = rnd(s5_pm_ff[0], s5_ps_ff[0]);
      s6_d_in[1] = rnd(s5_pm_ff[1], s5_ps_ff[1]);
      s6_part_in[DIR_REST]      = qsub(ONE, s5_v_ff[Q_F15]);
      s6_part_in[DIR_NORTH]     = qadd(qadd(ONE, s5_u3_ff[1]), s5_v_ff[Q_AY]);
      s6_part_in[DIR_EAST]      = qadd(qadd(ONE, s5_u3_ff[0]), s5_v_ff[Q_AX]);
      s6_part_in[DIR_SOUTH]     = qadd(qsub(ONE, s5_u3_ff[1]), s5_v_ff[Q_AY]);
      s6_part_in[DIR_WEST]      = qadd(qsub(ONE, s5_u3_ff[0]), s5_v_ff[Q_AX]);
      s6_part_in[DIR_NORTHEAST] = qadd(qadd(ONE, s5_u3_ff[0]), s5_u3_ff[1]);
      s6_part_in[DIR_NORTHWEST] = qadd(qsub(ONE, s5_u3_ff[0]), s5_u3_ff[1]);
      s6_part_in[DIR_SOUTHEAST] = qsub(qadd(ONE, s5_u3_ff[0]), s5_u3_ff[1]);
      s6_part_in[DIR_SOUTHWEST] = qsub(qsub(ONE, s5_u3_ff[0]), s5_u3_ff[1]);
      s6_f15_in = s5_v_ff[Q_F15];
      s6_wt_in  = s5_wt_ff;

      s7_poly_in[DIR_REST]      = s6_part_ff[DIR_REST];
      s7_poly_in[DIR_NORTH]     = qsub(s6_part_ff[DIR_NORTH], s6_f15_ff);
      s7_poly_in[DIR_EAST]      = qsub(s6_part_ff[DIR_EAST], s6_f15_ff);
      s7_poly_in[DIR_SOUTH]     = qsub(s6_part_ff[DIR_SOUTH], s6_f15_ff);
      s7_poly_in[DIR_WEST]      = qsub(s6_part_ff[DIR_WEST], s6_f15_ff);
      s7_poly_in[DIR_NORTHEAST] = qsub(qadd(s6_part_ff[DIR_NORTHEAST], s6_d_ff[0]), s6_f15_ff);
      s7_poly_in[DIR_NORTHWEST] = qsub(qadd(s6_part_ff[DIR_NORTHWEST], s6_d_ff[1]), s6_f15_ff);
      s7_poly_in[DIR_SOUTHEAST] = qsub(qadd(s6_part_ff[DIR_SOUTHEAST], s6_d_ff[1]), s6_f15_ff);
      s7_poly_in[DIR_SOUTHWEST] = qsub(qadd(s6_part_ff[DIR_SOUTHWEST], s6_d_ff[0]), s6_f15_ff);
      s7_wt_in = s6_wt_ff;

      // equilibrium, difference and relaxation
      for (int d = 0; d < NUM_DIR; d++) begin
         if (d == int'(DIR_REST)) begin
            wsel = s7_wt_ff[WT_49];
         end else if (d >= int'(DIR_NORTHEAST)) begin
            wsel = s7_wt_ff[WT_36];
         end else begin
            wsel = s7_wt_ff[WT_9];
         end
         s8_pm_in[d]    = mulmag(wsel, s7_poly_ff[d]);
         s8_ps_in[d]    = wsel[W-1] ^ s7_poly_ff[d][W-1];
         s9_feq_in[d]   = rnd(s8_pm_ff[d], s8_ps_ff[d]);
         s10_diff_in[d] = qsub(s9_feq_ff[d], dist_ff[9][d]);
         s11_pm_in[d]   = mulmag(omega_w, s10_diff_ff[d]);
         s11_ps_in[d]   = omega_w[W-1] ^ s10_diff_ff[d][W-1];
         s12_v_in[d]    = rnd(s11_pm_ff[d], s11_ps_ff[d]);
         s13_out_in[d]  = qadd(dist_ff[12][d], s12_v_ff[d]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff <= vld_in;
      end
      if (advance) begin
         dist_ff     <= dist_in;
         rho_ff      <= rho_in;
         ux_ff       <= ux_in;
         uy_ff       <= uy_in;
         s1_u3_ff    <= s1_u3_in;
         s1_pm_ff    <= s1_pm_in;
         s1_ps_ff    <= s1_ps_in;
         s2_v_ff     <= s2_v_in;
         s2_u3_ff    <= s2_u3_in;
         s3_uxx_ff   <= s3_uxx_in;
         s3_uyy_ff   <= s3_uyy_in;
         s3_u2_ff    <= s3_u2_in;
         s3_uxy2_ff  <= s3_uxy2_in;
         s3_wt_ff    <= s3_wt_in;
         s3_u3_ff    <= s3_u3_in;
         s4_sp_ff    <= s4_sp_in;
         s4_sm_ff    <= s4_sm_in;
         s4_pm_ff    <= s4_pm_in;
         s4_ps_ff    <= s4_ps_in;
         s4_wt_ff    <= s4_wt_in;
         s4_u3_ff    <= s4_u3_in;
         s5_v_ff     <= s5_v_in;
         s5_pm_ff    <= s5_pm_in;
         s5_ps_ff    <= s5_ps_in;
         s5_wt_ff    <= s5_wt_in;
         s5_u3_ff    <= s5_u3_in;
         s6_d_ff     <= s6_d_in;
         s6_part_ff  <= s6_part_in;
         s6_f15_ff   <= s6_f15_in;
         s6_wt_ff    <= s6_wt_in;
         s7_poly_ff  <= s7_poly_in;
         s7_wt_ff    <= s7_wt_in;
         s8_pm_ff    <= s8_pm_in;
         s8_ps_ff    <= s8_ps_in;
         s9_feq_ff   <= s9_feq_in;
         s10_diff_ff <= s10_diff_in;
         s11_pm_ff   <= s11_pm_in;
         s11_ps_ff   <= s11_ps_in;
         s12_v_ff    <= s12_v_in;
         s13_out_ff  <= s13_out_in;
      end
   end

   always_comb begin
      for (int d = 0; d < NUM_DIR; d++) begin
         out_dist[d] = s13_out_ff[d];
      end
   end

   assign out_valid = vld_ff[NS];
   assign out_rho   = rho_ff[NS];
   assign out_ux    = ux_ff[NS];
   assign out_uy    = uy_ff[NS];

endmodule
`default_nettype wire

>>> rtl/core/d2q_checker.sv
// port-level checks for the d2q9 bgk collision block and their bind
`default_nettype none
`include "d2q9_bgk_collision_top_macros.svh"
module d2q_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [4*VALUE_WIDTH-1:0] rsp_data
);
   logic rsp_stall;

   assign rsp_stall = rsp_valid && !rsp_ready;

   `D2Q_ASSERT_NEXT(a_rsp_valid_holds, rsp_stall, rsp_valid, "result dropped while stalled")
   `D2Q_ASSERT_NEXT(a_rsp_data_holds, rsp_stall, $stable(rsp_data), "result changed while stalled")
   `D2Q_ASSERT_NOW(a_req_ready_only_on_stall, !req_ready, rsp_stall, "cell refused without stall")
   `D2Q_ASSERT_ALWAYS_NEXT(a_reset_empties, reset, !rsp_valid, "result present after reset")

endmodule

bind d2q9_bgk_collision_top d2q_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_d2q_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  ({rsp_ch.rest_out, rsp_ch.density_out,
                rsp_ch.velocity_x_out, rsp_ch.velocity_y_out})
);
`default_nettype wire

>>> dv/d2q9_bgk_collision_top_tb.sv
// self-checking testbench for the d2q9 bgk collision block with a fixed-point predictor
`default_nettype none
module d2q9_bgk_collision_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import d2q_pkg::*;

   localparam int VW = 32;
   localparam int FB = 28;
   localparam int LATENCY = VW + 16;
   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [VW-1:0] f [NUM_DIR];
   } cell_type;

   typedef struct {
      logic signed [VW-1:0] f [NUM_DIR];
      logic signed [VW-1:0] rho;
      logic signed [VW-1:0] ux;
      logic signed [VW-1:0] uy;
   } collided_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [FB+1:0] csr_wr_data = '0;
   logic [FB+1:0] omega_q = 30'd268435456;

   d2q_req_if #(.VALUE_WIDTH(VW)) req_ch ();
   d2q_rsp_if #(.VALUE_WIDTH(VW)) rsp_ch ();

   d2q9_bgk_collision_top #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) DUT (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   cell_type pending_cells [$];
   collided_type expected_cells [$];
   int errors = 0;
   longint cycles = 0;
   bit no_idle = 0;
   int src_gap = 0, snk_gap = 0;

   // fixed-point helpers at block width
   function automatic longint clampv(longint x);
      if (x > VMAX) return VMAX;
      if (x < VMIN) return VMIN;
      return x;
   endfunction

   function automatic longint sat_add(longint a, longint b);
      return clampv(a + b);
   endfunction

   function automatic longint sat_sub(longint a, longint b);
      return clampv(a - b);
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      logic [127:0] p;
      logic [63:0] ua, ub;
      logic [127:0] q;
      bit neg;
      logic [127:0] lim;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      neg = (a < 0) != (b < 0);
      p = ua * ub;
      q = (p + (128'd1 << (FB - 1))) >> FB;
      lim = neg ? 128'd2147483648 : 128'd2147483647;
      if (q > lim) q = lim;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint fx_div(longint n, longint d);
      logic [127:0] un, ud, q, lim;
      bit neg;
      if (d == 0) return 0;
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      neg = (n < 0) != (d < 0);
      q = (un << FB) / ud;
      lim = neg ? 128'd2147483648 : 128'd2147483647;
      if (q > lim) q = lim;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint relax_dir(longint f, longint wrho, longint poly, longint om);
      return sat_add(f, fx_mul(om, sat_sub(fx_mul(wrho, poly), f)));
   endfunction

   function automatic collided_type collide_cell(cell_type c, logic [FB+1:0] om_bits);
      collided_type r;
      longint f [NUM_DIR];
      longint om, one, c19, c49, c136, c15, c45, rho, ux, uy, mx, my;
      longint u3x, u3y, uxx, uyy, uxy2, u2, f15, ax, ay, dp, dm, r9, r49, r36;
      for (int k = 0; k < NUM_DIR; k++) f[k] = longint'(c.f[k]);
      om = longint'(om_bits);
      one = 64'sd1 << FB;
      c19 = ((64'sd1 << FB) + 4) / 9;
      c49 = ((64'sd4 << FB) + 4) / 9;
      c136 = ((64'sd1 << FB) + 18) / 36;
      c15 = 64'sd3 << (FB - 1);
      c45 = 64'sd9 << (FB - 1);
      rho = 0;
      for (int k = 0; k < NUM_DIR; k++) rho += f[k];
      rho = clampv(rho);
      ux = 0;
      uy = 0;
      if (rho > 0) begin
         mx = f[DIR_EAST] + f[DIR_NORTHEAST] + f[DIR_SOUTHEAST]
              - f[DIR_WEST] - f[DIR_NORTHWEST] - f[DIR_SOUTHWEST];
         my = f[DIR_NORTH] + f[DIR_NORTHEAST] + f[DIR_NORTHWEST]
              - f[DIR_SOUTH] - f[DIR_SOUTHEAST] - f[DIR_SOUTHWEST];
         ux = fx_div(clampv(mx), rho);
         uy = fx_div(clampv(my), rho);
      end
      u3x = sat_add(sat_add(ux, ux), ux);
      u3y = sat_add(sat_add(uy, uy), uy);
      uxx = fx_mul(ux, ux);
      uyy = fx_mul(uy, uy);
      uxy2 = fx_mul(ux, uy);
      uxy2 = sat_add(uxy2, uxy2);
      u2 = sat_add(uxx, uyy);
      f15 = fx_mul(c15, u2);
      ax = fx_mul(c45, uxx);
      ay = fx_mul(c45, uyy);
      dp = fx_mul(c45, sat_add(u2, uxy2));
      dm = fx_mul(c45, sat_sub(u2, uxy2));
      r9 = fx_mul(c19, rho);
      r49 = fx_mul(c49, rho);
      r36 = fx_mul(c136, rho);
      r.f[DIR_REST] = VW'(relax_dir(f[0], r49, sat_sub(one, f15), om));
      r.f[DIR_NORTH] = VW'(relax_dir(f[1], r9,
         sat_sub(sat_add(sat_add(one, u3y), ay), f15), om));
      r.f[DIR_EAST] = VW'(relax_dir(f[2], r9,
         sat_sub(sat_add(sat_add(one, u3x), ax), f15), om));
      r.f[DIR_SOUTH] = VW'(relax_dir(f[3], r9,
         sat_sub(sat_add(sat_sub(one, u3y), ay), f15), om));
      r.f[DIR_WEST] = VW'(relax_dir(f[4], r9,
         sat_sub(sat_add(sat_sub(one, u3x), ax), f15), om));
      r.f[DIR_NORTHEAST] = VW'(relax_dir(f[5], r36,
         sat_sub(sat_add(sat_add(sat_add(one, u3x), u3y), dp), f15), om));
      r.f[DIR_NORTHWEST] = VW'(relax_dir(f[6], r36,
         sat_sub(sat_add(sat_add(sat_sub(one, u3x), u3y), dm), f15), om));
      r.f[DIR_SOUTHEAST] = VW'(relax_dir(f[7], r36,
         sat_sub(sat_add(sat_sub(sat_add(one, u3x), u3y), dm), f15), om));
      r.f[DIR_SOUTHWEST] = VW'(relax_dir(f[8], r36,
         sat_sub(sat_add(sat_sub(sat_sub(one, u3x), u3y), dp), f15), om));
      r.rho = VW'(rho);
      r.ux = VW'(ux);
      r.uy = VW'(uy);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_cells.push_back(collide_cell(pending_cells.pop_front(), omega_q));
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (src_gap > 0) begin
               src_gap <= src_gap - 1;
               req_ch.valid <= 0;
            end else if (pending_cells.size() != 0) begin
               req_ch.valid <= 1;
               req_ch.rest_in <= pending_cells[0].f[0];
               req_ch.north_in <= pending_cells[0].f[1];
               req_ch.east_in <= pending_cells[0].f[2];
               req_ch.south_in <= pending_cells[0].f[3];
               req_ch.west_in <= pending_cells[0].f[4];
               req_ch.northeast_in <= pending_cells[0].f[5];
               req_ch.northwest_in <= pending_cells[0].f[6];
               req_ch.southeast_in <= pending_cells[0].f[7];
               req_ch.southwest_in <= pending_cells[0].f[8];
               if (!no_idle && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 7);
            end else begin
               req_ch.valid <= 0;
            end
         end
      end
   end

   // monitor and response-side stalls
   always @(posedge clock) begin
      collided_type e;
      logic signed [VW-1:0] got [12];
      logic signed [VW-1:0] want [12];
      cycles <= cycles + 1;
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.rest_out, rsp_ch.north_out, rsp_ch.east_out, rsp_ch.south_out,
                    rsp_ch.west_out, rsp_ch.northeast_out, rsp_ch.northwest_out,
                    rsp_ch.southeast_out, rsp_ch.southwest_out, rsp_ch.density_out,
                    rsp_ch.velocity_x_out, rsp_ch.velocity_y_out};
            if (expected_cells.size() == 0) begin
               $display("%0t: unexpected transaction, actual density %0d", $time, got[9]);
               errors++;
            end else begin
               e = expected_cells.pop_front();
               for (int k = 0; k < NUM_DIR; k++) want[k] = e.f[k];
               want[9] = e.rho;
               want[10] = e.ux;
               want[11] = e.uy;
               for (int k = 0; k < 12; k++) begin
                  if (got[k] !== want[k]) begin
                     $display("%0t: field %0d expected %0d actual %0d", $time, k, want[k],
                              got[k]);
                     errors++;
                  end
               end
            end
         end
         if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= 1;
            if (!no_idle && $urandom_range(0, 9) == 0) snk_gap <= $urandom_range(1, 7);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic signed [VW-1:0] rand_value(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed(32'($urandom_range(0, 32'h0800_0000)));
         2: return -$signed(32'($urandom_range(0, 32'h0100_0000)));
         default: return 32'($urandom_range(0, 32'h0040_0000)) + 32'h0300_0000;
      endcase
   endfunction

   task automatic add_cell(logic signed [VW-1:0] v [NUM_DIR]);
      cell_type c;
      c.f = v;
      pending_cells.push_back(c);
   endtask

   task automatic drain();
      while (pending_cells.size() != 0 || req_ch.valid || expected_cells.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_omega(logic [FB+1:0] v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      omega_q = v;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   initial begin
      logic signed [VW-1:0] v [NUM_DIR];
      logic [FB+1:0] omegas [5];
      int mode;
      omegas = '{30'd0, 30'd536870912, 30'd134217728, 30'h3FFF_FFFF, 30'd268435456};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed cells at reset omega
      foreach (v[k]) v[k] = 0;
      add_cell(v);
      foreach (v[k]) v[k] = VW'(VMAX);
      add_cell(v);
      foreach (v[k]) v[k] = VW'(VMIN);
      add_cell(v);
      foreach (v[k]) v[k] = 32'h0200_0000;
      add_cell(v);
      for (int d = 0; d < NUM_DIR; d++) begin
         foreach (v[k]) v[k] = 0;
         v[d] = 32'h1000_0000;
         add_cell(v);
      end
      foreach (v[k]) v[k] = 0;
      v[DIR_EAST] = VW'(VMAX);
      v[DIR_REST] = 1;
      add_cell(v);
      foreach (v[k]) v[k] = 0;
      v[DIR_NORTH] = VW'(VMIN);
      v[DIR_REST] = VW'(VMAX);
      add_cell(v);
      foreach (v[k]) v[k] = -1;
      add_cell(v);
      drain();
      for (int p = 0; p < 5; p++) begin
         write_omega(omegas[p]);
         if (p == 4) no_idle = 1;
         for (int n = 0; n < 226; n++) begin
            mode = $urandom_range(0, 3);
            foreach (v[k]) v[k] = rand_value(mode);
            add_cell(v);
         end
         drain();
      end
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
